// ===== rtl/core/ate_pkg.sv =====
`default_nettype none

package ate_pkg;

  localparam int unsigned Depth = 256;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_FIND   = 3'd1,
    OP_MODIFY = 3'd2,
    OP_ZERO   = 3'd3,
    OP_REMOVE = 3'd4
  } ate_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } ate_status_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ate_ram_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/array_table_engine_core.sv =====
// channel   direction  handshake                  fields
// command   in         start_i high, busy_o low  op_i, index_i, value_i
// result    out        done_o, one cycle          status_o, found_index_o, old_value_o, count_o
//
// Append, zero, unused ops and index errors: result in the cycle after the transaction.
// Modify: reads the old entry, then writes the new value back in S_MODIFY.
// Find: one entry per cycle through the RAM read port, until a match or the end of the list.
// Remove: one entry shifted down per cycle, from the index to the end of the list.
// Reset clears the fill count and the result registers, not the entries; entries are undefined until written.
// The receiver cannot stall: a result is shown for one cycle only.
`default_nettype none

module array_table_engine_core import ate_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [2:0]       op_i,
  input  wire logic [7:0]       index_i,
  input  wire logic signed [31:0] value_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [7:0]            found_index_o,
  output logic signed [31:0]    old_value_o,
  output logic [8:0]            count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_MODIFY,
    S_REMOVE
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [AddrW-1:0]  ptr_q;
  logic [DataW-1:0]  val_q;
  logic              done_q;
  ate_status_e       status_q;
  logic [AddrW-1:0]  found_q;
  logic [DataW-1:0]  old_q;

  ate_ram_req_t      ram_req;
  logic [DataW-1:0]  rdata;

  logic              accept;
  logic              full;
  logic              in_range;
  logic              rem_last;
  logic [CntW-1:0]   ptr_next;
  logic [CntW-1:0]   ptr_next2;

  assign accept    = start_i && (state_q == S_IDLE);
  assign full      = (count_q == CntW'(Depth));
  assign in_range  = (CntW'(index_i) < count_q);
  assign rem_last  = ((CntW'(index_i) + CntW'(1)) == count_q);
  assign ptr_next  = CntW'(ptr_q) + CntW'(1);
  assign ptr_next2 = CntW'(ptr_q) + CntW'(2);

  // read and write never target the same entry in one cycle, so no forwarding
  always_comb begin
    ram_req       = '0;
    ram_req.waddr = ptr_q;
    ram_req.wdata = val_q;
    ram_req.raddr = ptr_next[AddrW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_i)
            OP_APPEND: begin
              ram_req.we    = !full;
              ram_req.waddr = count_q[AddrW-1:0];
              ram_req.wdata = value_i;
            end
            OP_FIND: begin
              ram_req.re    = (count_q != '0);
              ram_req.raddr = '0;
            end
            OP_MODIFY: begin
              ram_req.re    = in_range;
              ram_req.raddr = index_i;
            end
            OP_ZERO: begin
              ram_req.we    = in_range;
              ram_req.waddr = index_i;
              ram_req.wdata = '0;
            end
            OP_REMOVE: begin
              ram_req.re    = in_range && !rem_last;
              ram_req.raddr = index_i + AddrW'(1);
            end
            default: ;
          endcase
        end
      end
      S_FIND: begin
        ram_req.re = 1'b1;
      end
      S_MODIFY: begin
        ram_req.we = 1'b1;
      end
      S_REMOVE: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = rdata;
        ram_req.re    = 1'b1;
        ram_req.raddr = ptr_next2[AddrW-1:0];
      end
      default: ;
    endcase
  end

  ate_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ptr_q    <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      found_q  <= '0;
      old_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            status_q <= ST_OK;
            found_q  <= '0;
            old_q    <= '0;
            unique case (op_i)
              OP_APPEND: begin
                done_q <= 1'b1;
                if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  count_q <= count_q + CntW'(1);
                end
              end
              OP_FIND: begin
                ptr_q <= '0;
                if (count_q == '0) begin
                  done_q   <= 1'b1;
                  status_q <= ST_MISS;
                end else begin
                  state_q <= S_FIND;
                end
              end
              OP_MODIFY: begin
                ptr_q <= index_i;
                if (in_range) begin
                  state_q <= S_MODIFY;
                end else begin
                  done_q   <= 1'b1;
                  status_q <= ST_RANGE;
                end
              end
              OP_ZERO: begin
                done_q <= 1'b1;
                if (!in_range) begin
                  status_q <= ST_RANGE;
                end
              end
              OP_REMOVE: begin
                ptr_q <= index_i;
                if (!in_range) begin
                  done_q   <= 1'b1;
                  status_q <= ST_RANGE;
                end else if (rem_last) begin
                  done_q  <= 1'b1;
                  count_q <= count_q - CntW'(1);
                end else begin
                  state_q <= S_REMOVE;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        S_FIND: begin
          if (rdata == val_q) begin
            done_q  <= 1'b1;
            found_q <= ptr_q;
            state_q <= S_IDLE;
          end else if (ptr_next == count_q) begin
            done_q   <= 1'b1;
            status_q <= ST_MISS;
            state_q  <= S_IDLE;
          end else begin
            ptr_q <= ptr_next[AddrW-1:0];
          end
        end
        S_MODIFY: begin
          done_q  <= 1'b1;
          old_q   <= rdata;
          state_q <= S_IDLE;
        end
        S_REMOVE: begin
          if (ptr_next2 == count_q) begin
            done_q  <= 1'b1;
            count_q <= count_q - CntW'(1);
            state_q <= S_IDLE;
          end else begin
            ptr_q <= ptr_next[AddrW-1:0];
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign old_value_o   = old_q;
  assign count_o       = count_q;

`ifndef SYNTH
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted transaction neither busy nor done");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (count_o == CntW'(Depth)))
    else $error("full status with list not full");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_index_o != '0) |-> (status_o == ST_OK))
    else $error("found index reported on failed transaction");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (count_o != '0))
    else $error("walk started on an empty list");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ate_ram.sv =====
`default_nettype none

module ate_ram import ate_pkg::*; (
  input  wire logic         clk_i,
  input  wire ate_ram_req_t req_i,
  output logic [DataW-1:0]  rdata_o
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

`default_nettype wire

// ===== verif/array_table_engine_core_test.sv =====
module array_table_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ate_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned SettleCycles = 300;
  localparam int unsigned MaxReports = 100;

  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  found_idx;
    logic [31:0] old_val;
    logic [8:0]  count;
  } list_result_t;

  typedef struct {
    logic [2:0]   op;
    logic [7:0]   idx;
    logic [31:0]  val;
    bit           typed;
    list_result_t res;
  } dir_row_t;

  typedef enum {MODE_MIXED, MODE_GROW, MODE_SHRINK} traffic_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [2:0]         op_i;
  logic [7:0]         index_i;
  logic signed [31:0] value_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic [7:0]         found_index_o;
  logic signed [31:0] old_value_o;
  logic [8:0]         count_o;

  // mirror of the list contents
  logic [31:0]  list_mem [Depth];
  int unsigned  list_fill;

  list_result_t pending_results [$];
  list_result_t seen_exp;
  int unsigned  mismatch_cnt;
  int unsigned  cycle_cnt;
  int unsigned  burst_left;

  dir_row_t dir_rows [24] = '{
    '{OP_FIND,   8'd0,   32'h0000_0000, 1'b1, '{ST_MISS,  8'd0, 32'h0000_0000, 9'd0}},
    '{OP_MODIFY, 8'd0,   32'h0000_0001, 1'b1, '{ST_RANGE, 8'd0, 32'h0000_0000, 9'd0}},
    '{OP_ZERO,   8'd0,   32'h0000_0000, 1'b1, '{ST_RANGE, 8'd0, 32'h0000_0000, 9'd0}},
    '{OP_REMOVE, 8'd0,   32'h0000_0000, 1'b1, '{ST_RANGE, 8'd0, 32'h0000_0000, 9'd0}},
    '{OP_APPEND, 8'd0,   32'h7fff_ffff, 1'b1, '{ST_OK,    8'd0, 32'h0000_0000, 9'd1}},
    '{OP_APPEND, 8'd255, 32'h8000_0000, 1'b1, '{ST_OK,    8'd0, 32'h0000_0000, 9'd2}},
    '{OP_APPEND, 8'd0,   32'hffff_ffff, 1'b1, '{ST_OK,    8'd0, 32'h0000_0000, 9'd3}},
    '{OP_APPEND, 8'd0,   32'h0000_0000, 1'b1, '{ST_OK,    8'd0, 32'h0000_0000, 9'd4}},
    '{OP_FIND,   8'd0,   32'hffff_ffff, 1'b1, '{ST_OK,    8'd2, 32'h0000_0000, 9'd4}},
    '{OP_FIND,   8'd0,   32'h8000_0000, 1'b1, '{ST_OK,    8'd1, 32'h0000_0000, 9'd4}},
    '{OP_FIND,   8'd0,   32'h0001_2345, 1'b1, '{ST_MISS,  8'd0, 32'h0000_0000, 9'd4}},
    '{OP_MODIFY, 8'd1,   32'h0000_0005, 1'b1, '{ST_OK,    8'd0, 32'h8000_0000, 9'd4}},
    '{OP_MODIFY, 8'd255, 32'h0000_0009, 1'b1, '{ST_RANGE, 8'd0, 32'h0000_0000, 9'd4}},
    '{OP_ZERO,   8'd0,   32'haaaa_aaaa, 1'b1, '{ST_OK,    8'd0, 32'h0000_0000, 9'd4}},
    '{OP_FIND,   8'd0,   32'h0000_0000, 1'b1, '{ST_OK,    8'd0, 32'h0000_0000, 9'd4}},
    '{OP_REMOVE, 8'd1,   32'h0000_0000, 1'b0, '0},
    '{OP_FIND,   8'd0,   32'hffff_ffff, 1'b0, '0},
    '{OP_REMOVE, 8'd2,   32'h0000_0000, 1'b0, '0},
    '{OP_REMOVE, 8'd2,   32'h0000_0000, 1'b1, '{ST_RANGE, 8'd0, 32'h0000_0000, 9'd2}},
    '{OP_MODIFY, 8'd2,   32'h0000_0007, 1'b1, '{ST_RANGE, 8'd0, 32'h0000_0000, 9'd2}},
    '{OP_SPARE5, 8'd0,   32'h0000_0000, 1'b1, '{ST_OK,    8'd0, 32'h0000_0000, 9'd2}},
    '{OP_SPARE7, 8'd255, 32'hffff_ffff, 1'b1, '{ST_OK,    8'd0, 32'h0000_0000, 9'd2}},
    '{OP_SPARE6, 8'd170, 32'h5555_5555, 1'b1, '{ST_OK,    8'd0, 32'h0000_0000, 9'd2}},
    '{OP_FIND,   8'd0,   32'h7fff_ffff, 1'b1, '{ST_MISS,  8'd0, 32'h0000_0000, 9'd2}}
  };

  array_table_engine_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .index_i       (index_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .old_value_o   (old_value_o),
    .count_o       (count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic list_result_t predict_list_op(input logic [2:0] op,
                                                   input logic [7:0] idx,
                                                   input logic [31:0] val);
    list_result_t r;
    int unsigned  i;
    bit           hit;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    case (op)
      OP_APPEND: begin
        if (list_fill >= Depth) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_fill] = val;
          list_fill++;
        end
      end
      OP_FIND: begin
        r.status = ST_MISS;
        for (i = 0; i < list_fill && !hit; i++) begin
          if (list_mem[i] == val) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.found_idx = i[7:0];
          end
        end
      end
      OP_MODIFY: begin
        if (idx >= list_fill) begin
          r.status = ST_RANGE;
        end else begin
          r.old_val = list_mem[idx];
          list_mem[idx] = val;
        end
      end
      OP_ZERO: begin
        if (idx >= list_fill) begin
          r.status = ST_RANGE;
        end else begin
          list_mem[idx] = '0;
        end
      end
      OP_REMOVE: begin
        if (idx >= list_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (i = idx; i + 1 < list_fill; i++) begin
            list_mem[i] = list_mem[i + 1];
          end
          list_fill--;
        end
      end
      default: begin
      end
    endcase
    r.count = list_fill[8:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      4, 5: return 32'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] pick_index();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (list_fill > 0 && r < 7) begin
      return 8'($urandom_range(0, list_fill - 1));
    end else if (r == 7 && list_fill < Depth) begin
      return list_fill[7:0];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, got_v);
    end
  endtask

  // bursts of random length, random idle gaps (sometimes none) in between
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_cmd(input logic [2:0] op, input logic [7:0] idx,
                          input logic [31:0] val, input bit typed,
                          input list_result_t typed_res);
    list_result_t r;
    start_i <= 1'b1;
    op_i    <= op;
    index_i <= idx;
    value_i <= val;
    do @(posedge clk_i); while (busy_o);
    r = predict_list_op(op, idx, val);
    if (typed) begin
      r = typed_res;
    end
    @(negedge clk_i);
    pending_results.push_back(r);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic random_item(input traffic_mode_e mode);
    logic [2:0]  op;
    logic [7:0]  idx;
    logic [31:0] val;
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        if (r < 85) op = OP_APPEND;
        else if (r < 93) op = OP_FIND;
        else if (r < 97) op = OP_MODIFY;
        else op = OP_ZERO;
      end
      MODE_SHRINK: begin
        if (r < 15) op = OP_APPEND;
        else if (r < 30) op = OP_FIND;
        else if (r < 40) op = OP_MODIFY;
        else if (r < 45) op = OP_ZERO;
        else op = OP_REMOVE;
      end
      default: begin
        if (r < 30) op = OP_APPEND;
        else if (r < 50) op = OP_FIND;
        else if (r < 65) op = OP_MODIFY;
        else if (r < 75) op = OP_ZERO;
        else if (r < 92) op = OP_REMOVE;
        else op = 3'(OP_SPARE5 + $urandom_range(0, 2));
      end
    endcase
    idx = pick_index();
    if (op == OP_FIND && list_fill > 0 && $urandom_range(0, 9) < 6) begin
      val = list_mem[$urandom_range(0, list_fill - 1)];
    end else begin
      val = pick_value();
    end
    pace();
    send_cmd(op, idx, val, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout, %0d transactions outstanding", $time, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports) begin
          $display("%0t: result with no transaction outstanding, expected none, actual %0h",
                   $time, {status_o, found_index_o, old_value_o, count_o});
        end
      end else begin
        seen_exp = pending_results.pop_front();
        if (status_o !== seen_exp.status)
          report_mismatch("status", 32'(seen_exp.status), 32'(status_o));
        if (found_index_o !== seen_exp.found_idx)
          report_mismatch("found_index", 32'(seen_exp.found_idx), 32'(found_index_o));
        if (old_value_o !== seen_exp.old_val)
          report_mismatch("old_value", seen_exp.old_val, old_value_o);
        if (count_o !== seen_exp.count)
          report_mismatch("count", 32'(seen_exp.count), 32'(count_o));
      end
    end
  end

  initial begin
    int unsigned k;
    int unsigned extra;
    bit          was_full;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    op_i         = OP_APPEND;
    index_i      = '0;
    value_i      = '0;
    list_fill    = 0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    burst_left   = 0;
    extra        = 0;
    was_full     = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      pace();
      send_cmd(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val,
               dir_rows[i].typed, dir_rows[i].res);
    end
    drain();

    for (k = 0; k < 250; k++) random_item(MODE_MIXED);
    drain();

    // fill to the top, then keep hitting the full list
    while (!was_full || extra < 100) begin
      random_item(MODE_GROW);
      if (list_fill == Depth) was_full = 1'b1;
      if (was_full) extra++;
    end
    drain();

    for (k = 0; k < 200; k++) random_item(MODE_SHRINK);
    drain();

    for (k = 0; k < 250; k++) random_item(MODE_MIXED);
    drain();

    repeat (SettleCycles) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ate_pkg.sv
rtl/core/ate_ram.sv
rtl/core/array_table_engine_core.sv
verif/array_table_engine_core_test.sv
